// ----- rtl/core/pvf_pkg.sv -----
// Shared types and constants for the persistent voxel filter.
// Used by pvf_divider, pvf_ctrl, pvf_datapath and persistent_voxel_filter.
package pvf_pkg;

    localparam int VOXEL_W     = 12;
    localparam int FRAMES_W    = 5;
    localparam int FRAME_W     = 32;
    localparam int CMD_W       = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int DIV_RADIX   = 4;

    localparam logic [CMD_W-1:0] CMD_MARK      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_END_FRAME = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLASSIFY  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_VOXEL_SIZE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAMES_NEEDED = 2'd1;

    localparam logic [VOXEL_W-1:0]  VOXEL_SIZE_RST    = 12'd50;
    localparam logic [FRAMES_W-1:0] FRAMES_NEEDED_RST = 5'd3;
    localparam logic [FRAMES_W-1:0] RUN_MAX           = 5'd31;
    localparam logic [FRAME_W-1:0]  FRAME_RST         = 32'd1;

    typedef struct packed {
        logic [FRAME_W-1:0]  stamp;
        logic [FRAMES_W-1:0] run;
    } cell_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIVIDE,
        ST_INDEX,
        ST_READ,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic index_load;
        logic mem_read;
        logic finish;
        logic clr_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
    } ctrl_status_t;

endpackage

// ----- rtl/core/pvf_divider.sv -----
// Iterative unsigned divider, DIV_RADIX quotient bits per step.
// Depends on pvf_pkg for the divisor width and radix.
module pvf_divider #(
    parameter int QW = 16
) (
    input  logic                        aclk,
    input  logic                        load,
    input  logic                        step,
    input  logic [QW-1:0]               dividend,
    input  logic [pvf_pkg::VOXEL_W-1:0] divisor,
    output logic [QW-1:0]               quotient
);

    logic [QW-1:0]               num_reg;
    logic [QW-1:0]               num_next;
    logic [pvf_pkg::VOXEL_W-1:0] rem_reg;
    logic [pvf_pkg::VOXEL_W-1:0] rem_next;

    always_comb begin
        logic [pvf_pkg::VOXEL_W:0] trial;
        rem_next = rem_reg;
        num_next = num_reg;
        for (int i = 0; i < pvf_pkg::DIV_RADIX; i++) begin
            trial    = {rem_next, num_next[QW-1]};
            num_next = {num_next[QW-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                trial       = trial - {1'b0, divisor};
                num_next[0] = 1'b1;
            end
            rem_next = trial[pvf_pkg::VOXEL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            num_reg <= dividend;
            rem_reg <= '0;
        end else if (step) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = num_reg;

endmodule

// ----- rtl/core/pvf_ctrl.sv -----
// Controller state machine for the persistent voxel filter.
// Depends on pvf_pkg for states, command and status structs.
module pvf_ctrl #(
    parameter int COORD_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic [pvf_pkg::CMD_W-1:0] s_cmd,
    output logic                      s_ready,
    output logic                      m_valid,
    input  logic                      m_ready,
    input  pvf_pkg::ctrl_status_t     status,
    output pvf_pkg::ctrl_cmd_t        cmd
);

    localparam int DIV_STEPS = (COORD_BITS + pvf_pkg::DIV_RADIX - 1) / pvf_pkg::DIV_RADIX;
    localparam int CNT_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    pvf_pkg::state_t state_reg;
    pvf_pkg::state_t state_next;
    logic [CNT_W-1:0] step_cnt_reg;
    logic [CNT_W-1:0] step_cnt_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic             out_free;
    logic             needs_voxel;

    assign out_free    = !m_valid_reg || m_ready;
    assign needs_voxel = (s_cmd == pvf_pkg::CMD_MARK) || (s_cmd == pvf_pkg::CMD_CLASSIFY);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pvf_pkg::ST_CLEAR: begin
                if (status.clr_last) begin
                    state_next = pvf_pkg::ST_IDLE;
                end
            end
            pvf_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = needs_voxel ? pvf_pkg::ST_DIVIDE : pvf_pkg::ST_FINISH;
                end
            end
            pvf_pkg::ST_DIVIDE: begin
                if (step_cnt_reg == CNT_LAST) begin
                    state_next = pvf_pkg::ST_INDEX;
                end
            end
            pvf_pkg::ST_INDEX: state_next = pvf_pkg::ST_READ;
            pvf_pkg::ST_READ:  state_next = pvf_pkg::ST_FINISH;
            pvf_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = pvf_pkg::ST_IDLE;
                end
            end
            default: state_next = pvf_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd           = '0;
        s_ready       = 1'b0;
        step_cnt_next = step_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        case (state_reg)
            pvf_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
            pvf_pkg::ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.accept    = s_valid;
                step_cnt_next = '0;
            end
            pvf_pkg::ST_DIVIDE: begin
                cmd.div_step  = 1'b1;
                step_cnt_next = step_cnt_reg + CNT_W'(1);
            end
            pvf_pkg::ST_INDEX: cmd.index_load = 1'b1;
            pvf_pkg::ST_READ:  cmd.mem_read = 1'b1;
            pvf_pkg::ST_FINISH: begin
                if (out_free) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pvf_pkg::ST_CLEAR;
            step_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/core/pvf_datapath.sv -----
// Datapath: configuration registers, three axis dividers, grid memory,
// frame counter and result registers. Depends on pvf_pkg and pvf_divider.
module pvf_datapath #(
    parameter int GRID_SIDE  = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [pvf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pvf_pkg::VOXEL_W-1:0]     cfg_data,
    input  logic [pvf_pkg::CMD_W-1:0]       s_cmd,
    input  logic [COORD_BITS-1:0]           s_x_mm,
    input  logic [COORD_BITS-1:0]           s_y_mm,
    input  logic [COORD_BITS-1:0]           s_z_mm,
    output logic                            m_persistent,
    output logic                            m_out_of_grid,
    input  pvf_pkg::ctrl_cmd_t              cmd,
    output pvf_pkg::ctrl_status_t           status
);

    localparam int IDX_W     = $clog2(GRID_SIDE);
    localparam int CELLS     = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int DIV_STEPS = (COORD_BITS + pvf_pkg::DIV_RADIX - 1) / pvf_pkg::DIV_RADIX;
    localparam int QW        = DIV_STEPS * pvf_pkg::DIV_RADIX;
    localparam logic [QW-1:0]     HALF_Q    = QW'(GRID_SIDE / 2);
    localparam logic [ADDR_W-1:0] SIDE_A    = ADDR_W'(GRID_SIDE);
    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);

    logic [pvf_pkg::VOXEL_W-1:0]  voxel_size_reg;
    logic [pvf_pkg::FRAMES_W-1:0] frames_needed_reg;
    logic [pvf_pkg::FRAME_W-1:0]  frame_reg;
    logic [pvf_pkg::FRAME_W-1:0]  frame_next;
    logic [pvf_pkg::CMD_W-1:0]    cmd_reg;
    logic [2:0]                   neg_reg;
    logic [ADDR_W-1:0]            addr_reg;
    logic                         inside_reg;
    logic [ADDR_W-1:0]            clr_addr_reg;
    logic                         persistent_reg;
    logic                         persistent_next;
    logic                         out_of_grid_reg;
    logic                         out_of_grid_next;
    pvf_pkg::cell_t               rd_reg;

    logic [pvf_pkg::VOXEL_W-1:0]  divisor;
    logic [2:0][COORD_BITS-1:0]   axis_coord;
    logic [2:0][QW-1:0]           axis_quot;
    logic [2:0][IDX_W-1:0]        axis_idx;
    logic [2:0]                   axis_ok;
    logic [ADDR_W-1:0]            addr_row;
    logic [ADDR_W-1:0]            addr_calc;

    pvf_pkg::cell_t               mem [CELLS];
    logic                         mem_we;
    logic [ADDR_W-1:0]            mem_waddr;
    pvf_pkg::cell_t               mem_wdata;
    pvf_pkg::cell_t               mark_cell;
    logic                         mark_write;

    assign divisor       = (voxel_size_reg == '0) ? pvf_pkg::VOXEL_W'(1) : voxel_size_reg;
    assign axis_coord[0] = s_x_mm;
    assign axis_coord[1] = s_y_mm;
    assign axis_coord[2] = s_z_mm;

    for (genvar g = 0; g < 3; g++) begin : g_axis
        logic [COORD_BITS-1:0] mag;
        logic [QW-1:0]         offset;

        assign mag = axis_coord[g][COORD_BITS-1] ? (~axis_coord[g] + COORD_BITS'(1))
                                                 : axis_coord[g];

        pvf_divider #(
            .QW(QW)
        ) u_div (
            .aclk     (aclk),
            .load     (cmd.accept),
            .step     (cmd.div_step),
            .dividend (QW'(mag)),
            .divisor  (divisor),
            .quotient (axis_quot[g])
        );

        always_ff @(posedge aclk) begin
            if (cmd.accept) begin
                neg_reg[g] <= axis_coord[g][COORD_BITS-1];
            end
        end

        always_comb begin
            if (neg_reg[g]) begin
                axis_ok[g] = (axis_quot[g] <= HALF_Q);
                offset     = HALF_Q - axis_quot[g];
            end else begin
                axis_ok[g] = (axis_quot[g] < HALF_Q);
                offset     = HALF_Q + axis_quot[g];
            end
            axis_idx[g] = offset[IDX_W-1:0];
        end
    end

    assign addr_row  = ADDR_W'(axis_idx[0]) * SIDE_A + ADDR_W'(axis_idx[1]);
    assign addr_calc = addr_row * SIDE_A + ADDR_W'(axis_idx[2]);

    always_comb begin
        logic [pvf_pkg::FRAME_W-1:0] prev_frame;
        prev_frame       = frame_reg - pvf_pkg::FRAME_W'(1);
        mark_cell.stamp  = frame_reg;
        if ((rd_reg.stamp != '0) && (rd_reg.stamp == prev_frame)) begin
            mark_cell.run = (rd_reg.run < pvf_pkg::RUN_MAX) ? rd_reg.run + pvf_pkg::FRAMES_W'(1)
                                                            : rd_reg.run;
        end else begin
            mark_cell.run = pvf_pkg::FRAMES_W'(1);
        end
        mark_write = (cmd_reg == pvf_pkg::CMD_MARK) && inside_reg && (rd_reg.stamp != frame_reg);

        persistent_next  = 1'b0;
        out_of_grid_next = 1'b0;
        frame_next       = frame_reg;
        case (cmd_reg)
            pvf_pkg::CMD_MARK: out_of_grid_next = !inside_reg;
            pvf_pkg::CMD_CLASSIFY: begin
                out_of_grid_next = !inside_reg;
                persistent_next  = inside_reg && (rd_reg.stamp == frame_reg) &&
                                   (rd_reg.run >= frames_needed_reg);
            end
            pvf_pkg::CMD_END_FRAME: begin
                frame_next = frame_reg + pvf_pkg::FRAME_W'(1);
                if (frame_next == '0) begin
                    frame_next = pvf_pkg::FRAME_RST;
                end
            end
            default: frame_next = frame_reg;
        endcase

        if (cmd.clr_step) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = cmd.finish && mark_write;
            mem_waddr = addr_reg;
            mem_wdata = mark_cell;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_read) begin
            rd_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cmd_reg <= s_cmd;
        end
        if (cmd.index_load) begin
            addr_reg   <= addr_calc;
            inside_reg <= &axis_ok;
        end
        if (cmd.finish) begin
            persistent_reg  <= persistent_next;
            out_of_grid_reg <= out_of_grid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            voxel_size_reg    <= pvf_pkg::VOXEL_SIZE_RST;
            frames_needed_reg <= pvf_pkg::FRAMES_NEEDED_RST;
            frame_reg         <= pvf_pkg::FRAME_RST;
            clr_addr_reg      <= '0;
        end else begin
            if (cfg_we && (cfg_index == pvf_pkg::CFG_VOXEL_SIZE)) begin
                voxel_size_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == pvf_pkg::CFG_FRAMES_NEEDED)) begin
                frames_needed_reg <= cfg_data[pvf_pkg::FRAMES_W-1:0];
            end
            if (cmd.finish) begin
                frame_reg <= frame_next;
            end
            if (cmd.clr_step) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    assign status.clr_last = (clr_addr_reg == CELL_LAST);
    assign m_persistent    = persistent_reg;
    assign m_out_of_grid   = out_of_grid_reg;

endmodule

// ----- rtl/core/persistent_voxel_filter.sv -----
// Top level of the persistent voxel filter: controller plus datapath.
// Depends on pvf_pkg, pvf_ctrl, pvf_datapath and pvf_divider.
//
//  Port group   Direction  Contents
//  cfg_*        in         write enable, register index, write data
//  s_*          in         item: cmd, x_mm, y_mm, z_mm
//  m_*          out        item: persistent, out_of_grid
//
// A mark or classify item passes, from acceptance to the next acceptance, through
// the three axis dividers, which retire four quotient bits per cycle, then through
// the index, memory read and update steps.
// End-of-frame and unused commands go straight from acceptance to the update step.
// After reset the grid memory is cleared one entry per cycle, all GRID_SIDE^3
// entries, with s_ready low; configuration writes are taken.
// The result register frees the input side; an item waits in its last cycle only
// while the previous result is still held by m_ready low.
module persistent_voxel_filter #(
    parameter int GRID_SIDE  = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [pvf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pvf_pkg::VOXEL_W-1:0]     cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pvf_pkg::CMD_W-1:0]       s_cmd,
    input  logic [COORD_BITS-1:0]           s_x_mm,
    input  logic [COORD_BITS-1:0]           s_y_mm,
    input  logic [COORD_BITS-1:0]           s_z_mm,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_persistent,
    output logic                            m_out_of_grid
);

    pvf_pkg::ctrl_cmd_t    cmd;
    pvf_pkg::ctrl_status_t status;

    pvf_ctrl #(
        .COORD_BITS(COORD_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_cmd),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pvf_datapath #(
        .GRID_SIDE  (GRID_SIDE),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_cmd         (s_cmd),
        .s_x_mm        (s_x_mm),
        .s_y_mm        (s_y_mm),
        .s_z_mm        (s_z_mm),
        .m_persistent  (m_persistent),
        .m_out_of_grid (m_out_of_grid),
        .cmd           (cmd),
        .status        (status)
    );

endmodule
